// File: rtl/upq_pkg.sv
// upq_pkg: shared types, codes and default sizes of the priority queue.
// Used by upq_cell and unordered_priority_queue; depends on nothing.

package upq_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int PRIORITY_BITS_DEF = 8;
    localparam int PAYLOAD_BITS_DEF  = 32;

    // Operation codes on the kind port
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell
    typedef struct packed {
        logic push;   // accepted enqueue that fits
        logic pop;    // accepted dequeue from a non-empty queue
    } cell_ctrl_t;

endpackage

// File: rtl/upq_cell.sv
// upq_cell: one slot of the sorted job chain (priority plus payload).
// Depends on upq_pkg for the command struct.

module upq_cell #(
    parameter int PRIORITY_BITS = upq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = upq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     clk,
    input  upq_pkg::cell_ctrl_t      ctrl,
    input  logic                     occupied,
    input  logic [PRIORITY_BITS-1:0] new_prio,
    input  logic [PAYLOAD_BITS-1:0]  new_payload,
    input  logic                     left_open,
    input  logic [PRIORITY_BITS-1:0] left_prio,
    input  logic [PAYLOAD_BITS-1:0]  left_payload,
    input  logic [PRIORITY_BITS-1:0] right_prio,
    input  logic [PAYLOAD_BITS-1:0]  right_payload,
    output logic                     open,
    output logic [PRIORITY_BITS-1:0] prio,
    output logic [PAYLOAD_BITS-1:0]  payload
);

    logic [PRIORITY_BITS-1:0] prio_reg;
    logic [PRIORITY_BITS-1:0] prio_next;
    logic [PAYLOAD_BITS-1:0]  payload_reg;
    logic [PAYLOAD_BITS-1:0]  payload_next;

    // Slot gives way to a new job: empty, or holds a strictly lower priority.
    // Equal priorities stay ahead, which keeps arrival order among ties.
    assign open = !occupied || (prio_reg < new_prio);

    // Next slot contents
    always_comb
    begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.push && open)
        begin
            if (left_open)
            begin
                // insertion point is further up: shift back by one
                prio_next    = left_prio;
                payload_next = left_payload;
            end
            else
            begin
                // first open slot: the new job lands here
                prio_next    = new_prio;
                payload_next = new_payload;
            end
        end
        else if (ctrl.pop)
        begin
            // head leaves, everything moves forward one slot
            prio_next    = right_prio;
            payload_next = right_payload;
        end
    end

    // Slot storage, priority and payload: occupancy comes from the fill count
    always_ff @(posedge clk)
    begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

// File: rtl/unordered_priority_queue.sv
// unordered_priority_queue: bounded job queue, dequeue returns highest priority.
// Depends on upq_pkg and upq_cell (a chain of QUEUE_DEPTH sorted slots).
//
//  channel   | handshake                | fields
//  ----------+--------------------------+-----------------------------------------
//  command   | start / busy             | kind, job_priority, job_payload
//  result    | done (one-cycle strobe)  | status, out_priority, out_payload,
//            |                          | occupancy
//
// A command transfers at a rising edge with start high and busy low; busy is
// always low, so a command may transfer in every cycle. Its result is on the
// result ports for the cycle right after, marked by done. Each cell compares
// its own priority with the incoming one and all cells shift together, so
// the rate is one command per clock. Reset (rst_n low, asynchronous) empties
// the queue through the fill count; slot contents are not cleared. The
// receiver cannot stall: a result is gone after its done cycle.

module unordered_priority_queue #(
    parameter int QUEUE_DEPTH   = upq_pkg::QUEUE_DEPTH_DEF,
    parameter int PRIORITY_BITS = upq_pkg::PRIORITY_BITS_DEF,
    parameter int PAYLOAD_BITS  = upq_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             kind,
    input  logic [PRIORITY_BITS-1:0]         job_priority,
    input  logic [PAYLOAD_BITS-1:0]          job_payload,
    output logic                             done,
    output logic [1:0]                       status,
    output logic [PRIORITY_BITS-1:0]         out_priority,
    output logic [PAYLOAD_BITS-1:0]          out_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     done_reg;
    logic                     done_next;
    upq_pkg::status_t         status_reg;
    upq_pkg::status_t         status_next;
    logic [PRIORITY_BITS-1:0] out_prio_reg;
    logic [PRIORITY_BITS-1:0] out_prio_next;
    logic [PAYLOAD_BITS-1:0]  out_payload_reg;
    logic [PAYLOAD_BITS-1:0]  out_payload_next;
    logic [CNT_W-1:0]         occ_reg;

    logic                     full;
    logic                     empty;
    upq_pkg::cell_ctrl_t      ctrl;

    logic                     cell_open    [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] cell_prio    [QUEUE_DEPTH];
    logic [PAYLOAD_BITS-1:0]  cell_payload [QUEUE_DEPTH];

    assign busy  = 1'b0;
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    // Command decode for the cell chain
    always_comb
    begin
        ctrl.push = start && (kind == upq_pkg::KIND_ENQ) && !full;
        ctrl.pop  = start && (kind == upq_pkg::KIND_DEQ) && !empty;
    end

    // Cell chain, slot 0 holds the head (highest priority, oldest among ties)
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic                     l_open;
            logic [PRIORITY_BITS-1:0] l_prio;
            logic [PAYLOAD_BITS-1:0]  l_payload;
            logic [PRIORITY_BITS-1:0] r_prio;
            logic [PAYLOAD_BITS-1:0]  r_payload;

            if (gi == 0)
            begin : g_head
                assign l_open    = 1'b0;
                assign l_prio    = '0;
                assign l_payload = '0;
            end
            else
            begin : g_mid
                assign l_open    = cell_open[gi-1];
                assign l_prio    = cell_prio[gi-1];
                assign l_payload = cell_payload[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign r_prio    = '0;
                assign r_payload = '0;
            end
            else
            begin : g_body
                assign r_prio    = cell_prio[gi+1];
                assign r_payload = cell_payload[gi+1];
            end

            upq_cell #(
                .PRIORITY_BITS (PRIORITY_BITS),
                .PAYLOAD_BITS  (PAYLOAD_BITS)
            ) u_cell (
                .clk           (clk),
                .ctrl          (ctrl),
                .occupied      (CNT_W'(gi) < count_reg),
                .new_prio      (job_priority),
                .new_payload   (job_payload),
                .left_open     (l_open),
                .left_prio     (l_prio),
                .left_payload  (l_payload),
                .right_prio    (r_prio),
                .right_payload (r_payload),
                .open          (cell_open[gi]),
                .prio          (cell_prio[gi]),
                .payload       (cell_payload[gi])
            );
        end
    endgenerate

    // Fill count and result values
    always_comb
    begin
        count_next       = count_reg;
        done_next        = start;
        status_next      = upq_pkg::STATUS_OK;
        out_prio_next    = '0;
        out_payload_next = '0;
        if (start)
        begin
            case (kind)
                upq_pkg::KIND_ENQ:
                begin
                    if (full)
                        status_next = upq_pkg::STATUS_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                upq_pkg::KIND_DEQ:
                begin
                    if (empty)
                        status_next = upq_pkg::STATUS_EMPTY;
                    else
                    begin
                        count_next       = count_reg - CNT_W'(1);
                        out_prio_next    = cell_prio[0];
                        out_payload_next = cell_payload[0];
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Result payload registers
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        out_prio_reg    <= out_prio_next;
        out_payload_reg <= out_payload_next;
        occ_reg         <= count_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign out_priority = out_prio_reg;
    assign out_payload  = out_payload_reg;
    assign occupancy    = occ_reg;

endmodule
